// ===== design/assert_macros.svh =====
// Assertion macros used by the allocator core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHK_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed: lbl");

// The consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed: lbl");

`endif

// ===== design/bra_pkg.sv =====
`default_nettype none

package bra_pkg;

    localparam int MAP_BITS  = 1024;
    localparam int WORD_BITS = 64;
    localparam int SIZE_W    = 11;
    localparam int NUM_W     = 10;
    localparam int CFG_IDX_W = 2;

    localparam logic [SIZE_W-1:0] COUNT_MAX   = '1;
    localparam logic [SIZE_W-1:0] GROW_RESET  = 11'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROW_SIZE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SIZE     = 2'd2;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_RESERVE = 2'd2,
        OP_QUERY   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_BUSY    = 2'd1,
        STAT_NOGROW  = 2'd2,
        STAT_WASFREE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_SCAN,
        S_GROW,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== design/bra_if.sv =====
`default_nettype none

interface bra_req_if;
    logic                       valid;
    logic                       ready;
    bra_pkg::op_t               operation;
    logic [bra_pkg::NUM_W-1:0]  number;

    modport source (output valid, output operation, output number, input ready);
    modport sink   (input valid, input operation, input number, output ready);
endinterface

interface bra_rsp_if;
    logic                       valid;
    logic                       ready;
    bra_pkg::status_t           status;
    logic [bra_pkg::NUM_W-1:0]  granted_number;
    logic                       is_allocated;

    modport source (output valid, output status, output granted_number,
                    output is_allocated, input ready);
    modport sink   (input valid, input status, input granted_number,
                    input is_allocated, output ready);
endinterface

`default_nettype wire

// ===== design/bra_ram.sv =====
`default_nettype none

module bra_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/bra_scan.sv =====
`default_nettype none

// Finds the lowest clear bit of one map word whose resource number lies in [lo, hi).
module bra_scan #(
    parameter int WORD_BITS = 64,
    parameter int SW        = 11
) (
    input  wire logic [WORD_BITS-1:0]         word,
    input  wire logic [SW-1:0]                base,
    input  wire logic [SW-1:0]                lo,
    input  wire logic [SW-1:0]                hi,
    output logic                              found,
    output logic [$clog2(WORD_BITS)-1:0]      offset
);

    always_comb
    begin
        logic [SW:0] idx;
        found  = 1'b0;
        offset = '0;
        idx    = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            idx = {1'b0, base} + (SW+1)'(b);
            if (!word[b] && idx >= {1'b0, lo} && idx < {1'b0, hi})
            begin
                found  = 1'b1;
                offset = ($clog2(WORD_BITS))'(b);
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/bitmap_resource_allocator_core.sv =====
// Free, reserve and query pass from the accepted beat through S_LOOK and S_DONE into the
// result register; a reserve that extends the map passes through S_GROW for each growth step.
// Allocate reads the map words of its search in turn in S_SCAN (at most two
// passes over MAP_BITS/WORD_BITS words), plus one growth step if it extends the map.
// One item is in work at a time; the next beat is taken once the result register loads.
// Reset and any write to the initial, grow or max size register clear the map at once through per-word valid bits.
`default_nettype none

module bitmap_resource_allocator_core #(
    parameter int MAP_BITS  = bra_pkg::MAP_BITS,
    parameter int WORD_BITS = bra_pkg::WORD_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [bra_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bra_pkg::SIZE_W-1:0]      cfg_data,
    bra_req_if.sink                              req,
    bra_rsp_if.source                            rsp
);

    `include "assert_macros.svh"

    localparam int NW = MAP_BITS / WORD_BITS;
    localparam int RW = (NW > 1) ? $clog2(NW) : 1;
    localparam int BW = $clog2(WORD_BITS);
    localparam int CW = bra_pkg::SIZE_W;
    localparam int NUMW = bra_pkg::NUM_W;
    localparam int SW = ($clog2(MAP_BITS + 1) > CW) ? $clog2(MAP_BITS + 1) : CW;
    localparam logic [SW-1:0] MAP_SZ   = SW'(MAP_BITS);
    localparam logic [SW:0]   W_SZ     = (SW+1)'(WORD_BITS);
    localparam logic [SW:0]   W_MASK   = (SW+1)'(WORD_BITS - 1);

    bra_pkg::state_t   state_reg, state_next;
    logic [CW-1:0]     init_reg, init_next, grow_reg, grow_next, max_reg, max_next;
    logic [SW-1:0]     trk_reg, trk_next, ff_reg, ff_next, nf_reg, nf_next;
    logic [CW-1:0]     res_cnt_reg, res_cnt_next, alc_cnt_reg, alc_cnt_next;
    logic [NW-1:0]     vld_reg, vld_next;
    logic              rsp_vld_reg, rsp_vld_next;

    bra_pkg::op_t      op_reg, op_next;
    logic [NUMW-1:0]   num_reg, num_next;
    logic [SW-1:0]     base_reg, base_next, lo_reg, lo_next, hi_reg, hi_next;
    logic              pass2_reg, pass2_next;
    logic [WORD_BITS-1:0] word_reg, word_next;
    logic [SW-1:0]     sz_reg, sz_next, tgt_reg, tgt_next;
    bra_pkg::status_t  st_reg, st_next, rsp_st_reg, rsp_st_next;
    logic [NUMW-1:0]   gnt_reg, gnt_next, rsp_gnt_reg, rsp_gnt_next;
    logic              isa_reg, isa_next, rsp_isa_reg, rsp_isa_next;
    logic              rvld_reg;

    logic              ram_we;
    logic [RW-1:0]     ram_waddr, ram_raddr;
    logic [WORD_BITS-1:0] ram_wdata, ram_rdata, eff;

    logic [SW-1:0]     lim, lim_new, hi2;
    logic [SW:0]       init_sum, init_rnd, grow_sum, grow_rnd, g, nb;
    logic [SW+1:0]     grow_step;
    logic              p2_go, full, accept, cfg_hit;
    logic [SW-1:0]     n_ext, found_num;
    logic              n_in_map, n_bit, n_inr;
    logic              sc_found;
    logic [BW-1:0]     sc_off;

    bra_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NW)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign eff = rvld_reg ? ram_rdata : '0;

    bra_scan #(
        .WORD_BITS (WORD_BITS),
        .SW        (SW)
    ) u_scan (
        .word   (eff),
        .base   (base_reg),
        .lo     (lo_reg),
        .hi     (hi_reg),
        .found  (sc_found),
        .offset (sc_off)
    );

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == bra_pkg::S_IDLE);
    assign cfg_hit   = cfg_we && (cfg_index == bra_pkg::CFG_INITIAL_SIZE
                                  || cfg_index == bra_pkg::CFG_GROW_SIZE
                                  || cfg_index == bra_pkg::CFG_MAX_SIZE);

    assign rsp.valid          = rsp_vld_reg;
    assign rsp.status         = rsp_st_reg;
    assign rsp.granted_number = rsp_gnt_reg;
    assign rsp.is_allocated   = rsp_isa_reg;

    assign lim = (max_reg == '0 || SW'(max_reg) > MAP_SZ) ? MAP_SZ : SW'(max_reg);
    assign lim_new = (max_next == '0 || SW'(max_next) > MAP_SZ) ? MAP_SZ : SW'(max_next);
    assign init_sum = (SW+1)'(init_next) + W_MASK;
    assign init_rnd = init_sum & ~W_MASK;
    assign grow_sum = (SW+1)'(grow_reg) + W_MASK;
    assign grow_rnd = grow_sum & ~W_MASK;
    assign g = (grow_rnd == '0) ? W_SZ : grow_rnd;
    assign grow_step = (SW+2)'(sz_reg) + (SW+2)'(g);
    assign hi2 = (nf_reg < trk_reg) ? nf_reg : trk_reg;
    assign p2_go = ff_reg < hi2;
    assign full = (max_reg != '0)
                  && (({1'b0, res_cnt_reg} + {1'b0, alc_cnt_reg}) >= {1'b0, max_reg});
    assign n_ext = SW'(num_reg);
    assign n_in_map = n_ext < MAP_SZ;
    assign n_bit = n_in_map && eff[num_reg[BW-1:0]];
    assign n_inr = n_ext < trk_reg;
    assign nb = {1'b0, base_reg} + W_SZ;
    assign found_num = base_reg | SW'(sc_off);

    always_comb
    begin
        init_next    = init_reg;
        grow_next    = grow_reg;
        max_next     = max_reg;
        if (cfg_hit)
        begin
            unique case (cfg_index)
                bra_pkg::CFG_INITIAL_SIZE: init_next = cfg_data;
                bra_pkg::CFG_GROW_SIZE:    grow_next = cfg_data;
                default:                   max_next  = cfg_data;
            endcase
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        trk_next     = trk_reg;
        ff_next      = ff_reg;
        nf_next      = nf_reg;
        res_cnt_next = res_cnt_reg;
        alc_cnt_next = alc_cnt_reg;
        vld_next     = vld_reg;
        rsp_vld_next = rsp_vld_reg;
        op_next      = op_reg;
        num_next     = num_reg;
        base_next    = base_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        pass2_next   = pass2_reg;
        word_next    = word_reg;
        sz_next      = sz_reg;
        tgt_next     = tgt_reg;
        st_next      = st_reg;
        gnt_next     = gnt_reg;
        isa_next     = isa_reg;
        rsp_st_next  = rsp_st_reg;
        rsp_gnt_next = rsp_gnt_reg;
        rsp_isa_next = rsp_isa_reg;
        ram_we       = 1'b0;
        ram_waddr    = RW'(num_reg >> BW);
        ram_wdata    = eff;
        ram_raddr    = RW'(nf_reg >> BW);

        if (rsp_vld_reg && rsp.ready)
        begin
            rsp_vld_next = 1'b0;
        end

        unique case (state_reg)
            bra_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next  = req.operation;
                    num_next = req.number;
                    st_next  = bra_pkg::STAT_OK;
                    gnt_next = '0;
                    isa_next = 1'b0;
                    if (req.operation != bra_pkg::OP_ALLOC)
                    begin
                        ram_raddr  = RW'(req.number >> BW);
                        state_next = bra_pkg::S_LOOK;
                    end
                    else if (full)
                    begin
                        st_next    = bra_pkg::STAT_BUSY;
                        state_next = bra_pkg::S_DONE;
                    end
                    else if (nf_reg < trk_reg)
                    begin
                        base_next  = SW'({1'b0, nf_reg} & ~W_MASK);
                        lo_next    = nf_reg;
                        hi_next    = trk_reg;
                        pass2_next = 1'b0;
                        ram_raddr  = RW'(nf_reg >> BW);
                        state_next = bra_pkg::S_SCAN;
                    end
                    else if (p2_go)
                    begin
                        base_next  = SW'({1'b0, ff_reg} & ~W_MASK);
                        lo_next    = ff_reg;
                        hi_next    = hi2;
                        pass2_next = 1'b1;
                        ram_raddr  = RW'(ff_reg >> BW);
                        state_next = bra_pkg::S_SCAN;
                    end
                    else if (trk_reg >= lim)
                    begin
                        st_next    = bra_pkg::STAT_NOGROW;
                        state_next = bra_pkg::S_DONE;
                    end
                    else
                    begin
                        tgt_next   = trk_reg;
                        sz_next    = trk_reg;
                        word_next  = '0;
                        state_next = bra_pkg::S_GROW;
                    end
                end
            end

            bra_pkg::S_LOOK:
            begin
                state_next = bra_pkg::S_DONE;
                ram_wdata  = eff;
                unique case (op_reg)
                    bra_pkg::OP_FREE:
                    begin
                        if (!n_inr || !n_bit)
                        begin
                            st_next = bra_pkg::STAT_WASFREE;
                        end
                        else
                        begin
                            ram_we = 1'b1;
                            ram_wdata[num_reg[BW-1:0]] = 1'b0;
                            if (n_ext < ff_reg)
                            begin
                                ff_next = n_ext;
                            end
                            if (alc_cnt_reg != '0)
                            begin
                                alc_cnt_next = alc_cnt_reg - 1'b1;
                            end
                        end
                    end
                    bra_pkg::OP_RESERVE:
                    begin
                        if (n_inr && n_bit)
                        begin
                            st_next = bra_pkg::STAT_BUSY;
                        end
                        else if (!n_inr)
                        begin
                            if (n_ext >= lim)
                            begin
                                st_next = bra_pkg::STAT_NOGROW;
                            end
                            else
                            begin
                                word_next  = eff;
                                sz_next    = trk_reg;
                                tgt_next   = n_ext;
                                state_next = bra_pkg::S_GROW;
                            end
                        end
                        else
                        begin
                            ram_we = 1'b1;
                            ram_wdata[num_reg[BW-1:0]] = 1'b1;
                            if (res_cnt_reg != bra_pkg::COUNT_MAX)
                            begin
                                res_cnt_next = res_cnt_reg + 1'b1;
                            end
                        end
                    end
                    bra_pkg::OP_QUERY:
                    begin
                        isa_next = n_inr && n_bit;
                    end
                    bra_pkg::OP_ALLOC:
                    begin
                        st_next = bra_pkg::STAT_OK;
                    end
                endcase
            end

            bra_pkg::S_SCAN:
            begin
                if (sc_found)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = RW'(base_reg >> BW);
                    ram_wdata = eff;
                    ram_wdata[sc_off] = 1'b1;
                    if (pass2_reg)
                    begin
                        ff_next = found_num + 1'b1;
                    end
                    nf_next = found_num + 1'b1;
                    if (alc_cnt_reg != bra_pkg::COUNT_MAX)
                    begin
                        alc_cnt_next = alc_cnt_reg + 1'b1;
                    end
                    gnt_next   = NUMW'(found_num);
                    state_next = bra_pkg::S_DONE;
                end
                else if (nb < {1'b0, hi_reg})
                begin
                    base_next = SW'(nb);
                    ram_raddr = RW'(nb >> BW);
                end
                else if (!pass2_reg && p2_go)
                begin
                    base_next  = SW'({1'b0, ff_reg} & ~W_MASK);
                    lo_next    = ff_reg;
                    hi_next    = hi2;
                    pass2_next = 1'b1;
                    ram_raddr  = RW'(ff_reg >> BW);
                end
                else if (trk_reg >= lim)
                begin
                    st_next    = bra_pkg::STAT_NOGROW;
                    state_next = bra_pkg::S_DONE;
                end
                else
                begin
                    tgt_next   = trk_reg;
                    sz_next    = trk_reg;
                    word_next  = '0;
                    state_next = bra_pkg::S_GROW;
                end
            end

            bra_pkg::S_GROW:
            begin
                if (grow_step > (SW+2)'(tgt_reg))
                begin
                    trk_next  = (grow_step > (SW+2)'(lim)) ? lim : SW'(grow_step);
                    ram_we    = 1'b1;
                    ram_waddr = RW'(tgt_reg >> BW);
                    ram_wdata = word_reg;
                    ram_wdata[tgt_reg[BW-1:0]] = 1'b1;
                    if (op_reg == bra_pkg::OP_ALLOC)
                    begin
                        ff_next  = tgt_reg + 1'b1;
                        nf_next  = tgt_reg + 1'b1;
                        gnt_next = NUMW'(tgt_reg);
                        if (alc_cnt_reg != bra_pkg::COUNT_MAX)
                        begin
                            alc_cnt_next = alc_cnt_reg + 1'b1;
                        end
                    end
                    else if (res_cnt_reg != bra_pkg::COUNT_MAX)
                    begin
                        res_cnt_next = res_cnt_reg + 1'b1;
                    end
                    state_next = bra_pkg::S_DONE;
                end
                else
                begin
                    sz_next = SW'(grow_step);
                end
            end

            bra_pkg::S_DONE:
            begin
                if (!rsp_vld_reg || rsp.ready)
                begin
                    rsp_vld_next = 1'b1;
                    rsp_st_next  = st_reg;
                    rsp_gnt_next = gnt_reg;
                    rsp_isa_next = isa_reg;
                    state_next   = bra_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = bra_pkg::S_IDLE;
            end
        endcase

        if (ram_we)
        begin
            vld_next[ram_waddr] = 1'b1;
        end

        if (cfg_hit)
        begin
            vld_next     = '0;
            trk_next     = (init_rnd > {1'b0, lim_new}) ? lim_new : SW'(init_rnd);
            ff_next      = '0;
            nf_next      = '0;
            res_cnt_next = '0;
            alc_cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= bra_pkg::S_IDLE;
            init_reg    <= '0;
            grow_reg    <= bra_pkg::GROW_RESET;
            max_reg     <= '0;
            trk_reg     <= '0;
            ff_reg      <= '0;
            nf_reg      <= '0;
            res_cnt_reg <= '0;
            alc_cnt_reg <= '0;
            vld_reg     <= '0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            init_reg    <= init_next;
            grow_reg    <= grow_next;
            max_reg     <= max_next;
            trk_reg     <= trk_next;
            ff_reg      <= ff_next;
            nf_reg      <= nf_next;
            res_cnt_reg <= res_cnt_next;
            alc_cnt_reg <= alc_cnt_next;
            vld_reg     <= vld_next;
            rsp_vld_reg <= rsp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        num_reg     <= num_next;
        base_reg    <= base_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        pass2_reg   <= pass2_next;
        word_reg    <= word_next;
        sz_reg      <= sz_next;
        tgt_reg     <= tgt_next;
        st_reg      <= st_next;
        gnt_reg     <= gnt_next;
        isa_reg     <= isa_next;
        rsp_st_reg  <= rsp_st_next;
        rsp_gnt_reg <= rsp_gnt_next;
        rsp_isa_reg <= rsp_isa_next;
        rvld_reg    <= vld_reg[ram_raddr];
    end

    `CHK_SAME(a_trk_in_limit, 1'b1, trk_reg <= lim)
    `CHK_SAME(a_hint_order, 1'b1, ff_reg <= nf_reg && nf_reg <= trk_reg)
    `CHK_SAME(a_write_state, ram_we, state_reg == bra_pkg::S_LOOK
                                     || state_reg == bra_pkg::S_SCAN
                                     || state_reg == bra_pkg::S_GROW)
    `CHK_NEXT(a_done_to_rsp, state_reg == bra_pkg::S_DONE && state_next == bra_pkg::S_IDLE,
              rsp_vld_reg)

endmodule

`default_nettype wire

// ===== bench/bra_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bra_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [bra_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bra_pkg::SIZE_W-1:0]    cfg_data,
    bra_req_if                                 req,
    bra_rsp_if                                 rsp,
    output int                                 fail_count,
    output int                                 pending_count
);

    typedef struct packed {
        bra_pkg::status_t          status;
        logic [bra_pkg::NUM_W-1:0] granted_number;
        logic                      is_allocated;
    } grant_t;

    grant_t grant_q[$];

    logic [bra_pkg::MAP_BITS-1:0] usage_map;
    int unsigned reg_initial;
    int unsigned reg_grow;
    int unsigned reg_max;
    int unsigned tracked;
    int unsigned first_hint;
    int unsigned next_hint;
    int unsigned reserved_cnt;
    int unsigned alloc_cnt;

    function automatic int unsigned size_limit();
        if (reg_max == 0 || reg_max > bra_pkg::MAP_BITS)
            return bra_pkg::MAP_BITS;
        return reg_max;
    endfunction

    function automatic int unsigned word_round(int unsigned v);
        return ((v + bra_pkg::WORD_BITS - 1) / bra_pkg::WORD_BITS) * bra_pkg::WORD_BITS;
    endfunction

    function automatic bit map_bit(int unsigned n);
        if (n >= bra_pkg::MAP_BITS)
            return 1'b0;
        return usage_map[n];
    endfunction

    function automatic int unsigned first_clear(int unsigned lo, int unsigned hi);
        for (int unsigned i = lo; i < hi; i++)
        begin
            if (!map_bit(i))
                return i;
        end
        return hi;
    endfunction

    function automatic bra_pkg::status_t mark_and_grow(int unsigned n);
        int unsigned lim;
        int unsigned g;
        int unsigned sz;
        lim = size_limit();
        if (n >= tracked)
        begin
            g = word_round(reg_grow);
            if (g == 0)
                g = bra_pkg::WORD_BITS;
            if (n >= lim)
                return bra_pkg::STAT_NOGROW;
            sz = tracked + ((n - tracked) / g + 1) * g;
            tracked = (sz > lim) ? lim : sz;
        end
        if (n < bra_pkg::MAP_BITS)
            usage_map[n] = 1'b1;
        return bra_pkg::STAT_OK;
    endfunction

    function automatic void clear_map();
        int unsigned lim;
        int unsigned sz;
        lim = size_limit();
        sz = word_round(reg_initial);
        usage_map = '0;
        tracked = (sz > lim) ? lim : sz;
        first_hint = 0;
        next_hint = 0;
        reserved_cnt = 0;
        alloc_cnt = 0;
    endfunction

    function automatic grant_t predict_grant(bra_pkg::op_t op, int unsigned n);
        grant_t g;
        int unsigned num;
        int unsigned hi;
        int unsigned f;
        bit first_pass;
        g = '{status: bra_pkg::STAT_OK, granted_number: '0, is_allocated: 1'b0};
        case (op)
            bra_pkg::OP_ALLOC:
            begin
                if (reg_max != 0 && reserved_cnt + alloc_cnt >= reg_max)
                    g.status = bra_pkg::STAT_BUSY;
                else
                begin
                    num = first_clear(next_hint, tracked);
                    first_pass = num < tracked;
                    if (!first_pass)
                    begin
                        num = tracked;
                        if (first_hint < next_hint)
                        begin
                            hi = (next_hint < tracked) ? next_hint : tracked;
                            f = first_clear(first_hint, hi);
                            if (f < hi)
                                num = f;
                        end
                    end
                    g.status = mark_and_grow(num);
                    if (g.status == bra_pkg::STAT_OK)
                    begin
                        if (!first_pass)
                            first_hint = num + 1;
                        next_hint = num + 1;
                        if (alloc_cnt < bra_pkg::COUNT_MAX)
                            alloc_cnt++;
                        g.granted_number = num[bra_pkg::NUM_W-1:0];
                    end
                end
            end
            bra_pkg::OP_FREE:
            begin
                if (n >= tracked || !map_bit(n))
                    g.status = bra_pkg::STAT_WASFREE;
                else
                begin
                    usage_map[n] = 1'b0;
                    if (n < first_hint)
                        first_hint = n;
                    if (alloc_cnt > 0)
                        alloc_cnt--;
                end
            end
            bra_pkg::OP_RESERVE:
            begin
                if (n < tracked && map_bit(n))
                    g.status = bra_pkg::STAT_BUSY;
                else
                begin
                    g.status = mark_and_grow(n);
                    if (g.status == bra_pkg::STAT_OK && reserved_cnt < bra_pkg::COUNT_MAX)
                        reserved_cnt++;
                end
            end
            default:
                g.is_allocated = (n < tracked && map_bit(n));
        endcase
        return g;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        grant_t want;
        grant_t got;
        if (!rst_n)
        begin
            reg_initial = 0;
            reg_grow = bra_pkg::GROW_RESET;
            reg_max = 0;
            clear_map();
            grant_q.delete();
            fail_count = 0;
            pending_count = 0;
        end
        else
        begin
            if (cfg_we && (cfg_index == bra_pkg::CFG_INITIAL_SIZE
                           || cfg_index == bra_pkg::CFG_GROW_SIZE
                           || cfg_index == bra_pkg::CFG_MAX_SIZE))
            begin
                case (cfg_index)
                    bra_pkg::CFG_INITIAL_SIZE: reg_initial = cfg_data;
                    bra_pkg::CFG_GROW_SIZE:    reg_grow = cfg_data;
                    default:                   reg_max = cfg_data;
                endcase
                clear_map();
            end
            if (req.valid && req.ready)
                grant_q.push_back(predict_grant(req.operation, req.number));
            if (rsp.valid && rsp.ready)
            begin
                got = '{status: rsp.status, granted_number: rsp.granted_number,
                        is_allocated: rsp.is_allocated};
                if (grant_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat %p", $time, got);
                    fail_count++;
                end
                else
                begin
                    want = grant_q.pop_front();
                    if (got.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, got.status);
                        fail_count++;
                    end
                    if (got.granted_number !== want.granted_number)
                    begin
                        $display("%0t: granted_number expected %0d actual %0d", $time,
                                 want.granted_number, got.granted_number);
                        fail_count++;
                    end
                    if (got.is_allocated !== want.is_allocated)
                    begin
                        $display("%0t: is_allocated expected %0d actual %0d", $time,
                                 want.is_allocated, got.is_allocated);
                        fail_count++;
                    end
                end
            end
            pending_count = grant_q.size();
        end
    end

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

    typedef logic [bra_pkg::NUM_W-1:0]     num_t;
    typedef logic [bra_pkg::SIZE_W-1:0]    size_t;
    typedef logic [bra_pkg::CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_UNUSED = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    cfg_idx_t             cfg_index;
    size_t                cfg_data;
    int                   fail_count;
    int                   pending_count;
    bit                   hold_req;

    bra_req_if req ();
    bra_rsp_if rsp ();

    bitmap_resource_allocator_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp)
    );

    bra_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .req           (req),
        .rsp           (rsp),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 10)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_beat(bra_pkg::op_t op, num_t n);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid     <= 1'b1;
        req.operation <= op;
        req.number    <= n;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    task automatic drain();
        @(posedge clk);
        req.valid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, size_t v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_regs(size_t ini, size_t grw, size_t mx);
        drain();
        write_reg(bra_pkg::CFG_MAX_SIZE, mx);
        write_reg(bra_pkg::CFG_GROW_SIZE, grw);
        write_reg(bra_pkg::CFG_INITIAL_SIZE, ini);
    endtask

    task automatic random_beats(int count, int unsigned span);
        bra_pkg::op_t op;
        num_t n;
        int unsigned r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 9);
            if (r < 4)
                op = bra_pkg::OP_ALLOC;
            else if (r < 6)
                op = bra_pkg::OP_FREE;
            else if (r < 8)
                op = bra_pkg::OP_RESERVE;
            else
                op = bra_pkg::OP_QUERY;
            if ($urandom_range(0, 4) == 0)
                n = num_t'($urandom_range(0, 1023));
            else
                n = num_t'($urandom_range(0, span));
            send_beat(op, n);
        end
    endtask

    initial
    begin
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            int unsigned r;
            int unsigned len;
            if (hold_req)
            begin
                hold_req = 1'b0;
                rsp.ready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            else
            begin
                r = $urandom_range(0, 9);
                if (r < 6)
                begin
                    rsp.ready <= 1'b1;
                    len = $urandom_range(1, 30);
                end
                else
                begin
                    rsp.ready <= 1'b0;
                    len = (r == 9) ? $urandom_range(20, 80) : $urandom_range(1, 3);
                end
                repeat (len) @(posedge clk);
            end
        end
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        hold_req      = 1'b0;
        req.valid     = 1'b0;
        req.operation = bra_pkg::OP_ALLOC;
        req.number    = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(bra_pkg::OP_QUERY, 10'd0);
        send_beat(bra_pkg::OP_FREE, 10'd0);
        send_beat(bra_pkg::OP_ALLOC, 10'd1023);
        send_beat(bra_pkg::OP_ALLOC, 10'd0);
        send_beat(bra_pkg::OP_RESERVE, 10'd1);
        send_beat(bra_pkg::OP_RESERVE, 10'd1);
        send_beat(bra_pkg::OP_ALLOC, 10'd0);
        send_beat(bra_pkg::OP_FREE, 10'd0);
        send_beat(bra_pkg::OP_ALLOC, 10'd0);
        send_beat(bra_pkg::OP_FREE, 10'd1);
        send_beat(bra_pkg::OP_FREE, 10'd1);
        send_beat(bra_pkg::OP_RESERVE, 10'd1023);
        send_beat(bra_pkg::OP_QUERY, 10'd1023);
        send_beat(bra_pkg::OP_QUERY, 10'd700);
        send_beat(bra_pkg::OP_FREE, 10'd1000);
        send_beat(bra_pkg::OP_ALLOC, 10'd0);
        send_beat(bra_pkg::OP_QUERY, 10'd5);

        set_regs(11'd0, 11'd0, 11'd3);
        send_beat(bra_pkg::OP_RESERVE, 10'd200);
        send_beat(bra_pkg::OP_RESERVE, 10'd2);
        send_beat(bra_pkg::OP_ALLOC, 10'd0);
        send_beat(bra_pkg::OP_ALLOC, 10'd0);
        send_beat(bra_pkg::OP_ALLOC, 10'd0);
        send_beat(bra_pkg::OP_FREE, 10'd0);
        send_beat(bra_pkg::OP_ALLOC, 10'd0);

        drain();
        write_reg(CFG_UNUSED, 11'h7ff);
        set_regs(11'd1024, 11'd64, 11'd0);
        hold_req = 1'b1;
        random_beats(60, 1023);

        set_regs(11'd0, 11'd1, 11'd0);
        random_beats(90, 150);

        set_regs(11'd100, 11'd100, 11'd130);
        random_beats(90, 160);

        set_regs(11'd0, 11'd1024, 11'd1024);
        random_beats(60, 1023);

        set_regs(11'd5, 11'd2047, 11'd8);
        random_beats(60, 20);

        set_regs(11'h7ff, 11'h7ff, 11'h7ff);
        random_beats(60, 1023);

        set_regs(11'd64, 11'd64, 11'd0);
        hold_req = 1'b1;
        random_beats(100, 200);

        for (int p = 0; p < 4; p++)
        begin
            set_regs(size_t'($urandom_range(0, 2047)), size_t'($urandom_range(0, 2047)),
                     size_t'($urandom_range(0, 2047)));
            random_beats(50, $urandom_range(30, 1023));
        end

        drain();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
